// File: hdl/afd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// afd_pkg
// Shared types and constants of the framed 4-bit ADPCM decoder: stream and
// PCM word layouts, frame and coefficient bank sizes, datapath widths.
// ---------------------------------------------------------------------------
package afd_pkg;

	// coefficient bank and register port
	localparam int NUM_COEF    = 8;
	localparam int COEF_IDX_W  = $clog2(NUM_COEF);
	localparam int CFG_ADDR_W  = COEF_IDX_W + 2;
	localparam int CFG_DATA_W  = 32;

	// frame layout: one header byte, then data bytes
	localparam int FRAME_BYTES = 8;
	localparam int FPOS_W      = $clog2(FRAME_BYTES);

	// sample datapath
	localparam int PCM_W       = 16;
	localparam int NIB_W       = 4;
	localparam int SHIFT_W     = 4;
	localparam int FRAC_BITS   = 11;
	localparam int ROUND_BIAS  = 1024;
	localparam int ACC_W       = 36;

	// input word: one stream byte with its side flags
	typedef struct packed {
		logic [7:0] stream_byte;
		logic       start_req;
		logic       high_only;
	} byte_word_t;

	// output word: one decoded sample
	typedef struct packed {
		logic signed [PCM_W-1:0] pcm_sample;
		logic                    last_of_byte;
	} pcm_word_t;

endpackage

// File: hdl/adpcm_frame_decoder.sv
`timescale 1ns / 1ps
// An accepted byte is held in the input register; its samples go from there to the output register.
// A data byte yields two samples (one with high_only), a header byte none, and a new
// byte is taken only once the held one is done; the two samples of a byte share one
// decode datapath, the second needing the first through the history registers.
// Reset: arst_n clears frame position, history, header fields, coefficients and
// all valid flags; no clearing pass.
// ---------------------------------------------------------------------------
// adpcm_frame_decoder
// Framed 4-bit ADPCM decoder: header bytes select predictor and scale, data
// bytes yield two clamped 16-bit samples (one with high_only) through a two-tap predictor.
// ---------------------------------------------------------------------------
module adpcm_frame_decoder
	import afd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// stream byte channel
	input  logic                  byte_valid,
	output logic                  byte_stall,
	input  byte_word_t            byte_word,
	// PCM sample channel
	output logic                  pcm_valid,
	input  logic                  pcm_stall,
	output pcm_word_t             pcm_word,
	// register port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam logic signed [ACC_W-1:0] BIAS    = ACC_W'(ROUND_BIAS);
	localparam logic signed [ACC_W-1:0] PCM_MAX = ACC_W'((1 << (PCM_W-1)) - 1);
	localparam logic signed [ACC_W-1:0] PCM_MIN = -ACC_W'(1 << (PCM_W-1));

	// registers
	logic                    v_s1;
	byte_word_t              w_s1;
	logic                    phase_q;
	logic [FPOS_W-1:0]       fpos_q;
	logic [COEF_IDX_W-1:0]   pred_q;
	logic [SHIFT_W-1:0]      shift_q;
	logic signed [PCM_W-1:0] hn_q;
	logic signed [PCM_W-1:0] ho_q;
	logic [CFG_DATA_W-1:0]   coef_q [NUM_COEF];
	logic                    out_valid_q;
	pcm_word_t               out_word_q;

	// combinational
	logic                    out_free;
	logic [FPOS_W-1:0]       pos_eff;
	logic                    is_hdr;
	logic                    clr_hist;
	logic signed [PCM_W-1:0] h1;
	logic signed [PCM_W-1:0] h2;
	logic [NIB_W-1:0]        nib;
	logic [CFG_DATA_W-1:0]   pair;
	logic signed [PCM_W-1:0] c1;
	logic signed [PCM_W-1:0] c2;
	logic signed [2*PCM_W-1:0] prod1;
	logic signed [2*PCM_W-1:0] prod2;
	logic signed [ACC_W-1:0] nib_term;
	logic signed [ACC_W-1:0] acc;
	logic signed [ACC_W-1:0] quo;
	logic signed [PCM_W-1:0] sample;
	logic                    last;
	logic                    fire;
	logic                    done;
	logic                    cfg_wr;

	// item control
	assign out_free = !out_valid_q || !pcm_stall;
	assign pos_eff  = w_s1.start_req ? '0 : fpos_q;
	assign is_hdr   = (pos_eff == '0);
	assign last     = phase_q || w_s1.high_only;
	assign fire     = v_s1 && !is_hdr && out_free;
	assign done     = v_s1 && (is_hdr || (out_free && last));
	assign byte_stall = v_s1 && !done;

	// history, cleared by a start request on the first sample only
	assign clr_hist = w_s1.start_req && !phase_q;
	assign h1 = clr_hist ? '0 : hn_q;
	assign h2 = clr_hist ? '0 : ho_q;

	// predictor taps
	assign pair  = coef_q[pred_q];
	assign c1    = pair[CFG_DATA_W-1 -: PCM_W];
	assign c2    = pair[PCM_W-1:0];
	assign prod1 = c1 * h1;
	assign prod2 = c2 * h2;

	// high nibble first, then low nibble
	assign nib      = phase_q ? w_s1.stream_byte[NIB_W-1:0] : w_s1.stream_byte[7 -: NIB_W];
	assign nib_term = {{(ACC_W-NIB_W){nib[NIB_W-1]}}, nib} <<< (FRAC_BITS + int'(shift_q));
	assign acc      = nib_term + ACC_W'(prod1) + ACC_W'(prod2) + BIAS;
	assign quo      = acc >>> FRAC_BITS;

	// clamp to the sample range
	always_comb begin
		if (quo > PCM_MAX) begin
			sample = PCM_MAX[PCM_W-1:0];
		end else if (quo < PCM_MIN) begin
			sample = PCM_MIN[PCM_W-1:0];
		end else begin
			sample = quo[PCM_W-1:0];
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!byte_stall) begin
			v_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!byte_stall && byte_valid) begin
			w_s1 <= byte_word;
		end
	end

	// decoder state: phase, frame position, header fields, history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
			fpos_q  <= '0;
			pred_q  <= '0;
			shift_q <= '0;
			hn_q    <= '0;
			ho_q    <= '0;
		end else begin
			if (fire) begin
				phase_q <= !last;
				ho_q    <= h1;
				hn_q    <= sample;
			end
			if (v_s1 && is_hdr) begin
				pred_q  <= w_s1.stream_byte[4 +: COEF_IDX_W];
				shift_q <= w_s1.stream_byte[SHIFT_W-1:0];
				if (w_s1.start_req) begin
					hn_q <= '0;
					ho_q <= '0;
				end
			end
			if (done) begin
				fpos_q <= pos_eff + FPOS_W'(1);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_word_q.pcm_sample   <= sample;
			out_word_q.last_of_byte <= last;
		end
	end

	assign pcm_valid = out_valid_q;
	assign pcm_word  = out_word_q;

	// coefficient registers
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_COEF; i++) begin
				coef_q[i] <= '0;
			end
		end else if (cfg_wr) begin
			coef_q[paddr[CFG_ADDR_W-1:2]] <= pwdata;
		end
	end

	assign prdata = coef_q[paddr[CFG_ADDR_W-1:2]];
	assign pready = 1'b1;

endmodule

// File: hdl/afd_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// afd_checker
// Port-level checks of the ADPCM decoder, bound to the top level.
// ---------------------------------------------------------------------------
module afd_checker
	import afd_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       byte_valid,
	input logic       byte_stall,
	input logic       pcm_valid,
	input logic       pcm_stall,
	input pcm_word_t  pcm_word
);

	// a stalled sample word holds
	a_pcm_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pcm_valid && pcm_stall |=> pcm_valid && $stable(pcm_word))
		else $error("stalled pcm word changed");

	// the high-nibble sample of a full byte is followed at once by its low-nibble sample
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		pcm_valid && !pcm_stall && !pcm_word.last_of_byte |=> pcm_valid && pcm_word.last_of_byte)
		else $error("second sample of byte missing");

	// an empty input side stays open
	a_idle_open: assert property (@(posedge clk) disable iff (!arst_n)
		!byte_valid && !byte_stall |=> !byte_stall)
		else $error("stall raised with nothing in flight");

	// no sample word while in reset
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !pcm_valid)
		else $error("pcm word valid during reset");

endmodule

bind adpcm_frame_decoder afd_checker u_afd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.byte_valid (byte_valid),
	.byte_stall (byte_stall),
	.pcm_valid  (pcm_valid),
	.pcm_stall  (pcm_stall),
	.pcm_word   (pcm_word)
);
